### src/cct_pkg.sv
package cct_pkg;

  localparam int unsigned PositionBitsDef = 16;
  localparam int unsigned LengthBitsDef   = 8;
  localparam int unsigned QueueDepth      = 4;

  localparam logic [4:0] KindVal = 5'd0;
  localparam logic [4:0] KindSq  = 5'd1;
  localparam logic [4:0] KindDq  = 5'd2;
  localparam logic [4:0] ClsSkip = 5'd26;
  localparam logic [4:0] ClsNl   = 5'd27;
  localparam logic [4:0] ClsSl   = 5'd28;

  localparam logic [4:0] ClassTable [128] = '{
    5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26,
    5'd26, 5'd26, 5'd27, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26,
    5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26,
    5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26, 5'd26,
    5'd26, 5'd3,  5'd2,  5'd4,  5'd5,  5'd6,  5'd7,  5'd1,
    5'd8,  5'd9,  5'd0,  5'd0,  5'd10, 5'd0,  5'd11, 5'd28,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17,
    5'd18, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd19, 5'd20, 5'd21, 5'd0,  5'd0,
    5'd22, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd23, 5'd24, 5'd25, 5'd0,  5'd26
  };

  typedef enum logic [5:0] {
    ModeIdle    = 6'b000001,
    ModeWord    = 6'b000010,
    ModeSlash   = 6'b000100,
    ModeComment = 6'b001000,
    ModeSq      = 6'b010000,
    ModeDq      = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [7:0]  token_length;
    logic        length_saturated;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [1:0] count;
    out_t       tok0;
    out_t       tok1;
  } push_t;

endpackage

### src/cct_front.sv
module cct_front #(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned LENGTH_BITS   = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  cct_pkg::in_t  in_data_i,
  input  logic          room_i,
  output cct_pkg::push_t push_o
);
  import cct_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;

  mode_e                    mode_q, mode_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [LENGTH_BITS-1:0]   len_q, len_d;
  logic                     ovf_q, ovf_d;

  logic       fire;
  logic       is_end;
  logic [4:0] cls;
  logic       from_idle;
  logic [1:0] n;
  out_t       value_tok, punct_tok, tok0, tok1;

  assign fire   = in_valid_i && room_i;
  assign is_end = in_data_i.end_of_text || (in_data_i.char_code == 8'd0);
  assign cls    = in_data_i.char_code[7] ? ClsSkip : ClassTable[in_data_i.char_code[6:0]];

  always_comb begin
    value_tok.token_kind       = KindVal;
    value_tok.token_start      = 16'(start_q);
    value_tok.token_length     = 8'(len_q);
    value_tok.length_saturated = ovf_q;
    value_tok.last             = 1'b0;
    punct_tok                  = '0;
    punct_tok.token_kind       = cls;
  end

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q + 1'b1;
    start_d   = start_q;
    len_d     = len_q;
    ovf_d     = ovf_q;
    from_idle = 1'b0;
    n         = 2'd0;
    tok0      = value_tok;
    tok1      = punct_tok;
    if (is_end) begin
      if (mode_q == ModeWord || mode_q == ModeSq || mode_q == ModeDq) begin
        n = 2'd1;
      end
      mode_d  = ModeIdle;
      pos_d   = '0;
      start_d = '0;
      len_d   = '0;
      ovf_d   = 1'b0;
    end else begin
      case (mode_q)
        ModeSq, ModeDq: begin
          if ((mode_q == ModeSq && cls == KindSq) || (mode_q == ModeDq && cls == KindDq)) begin
            n      = 2'd2;
            mode_d = ModeIdle;
          end else if (len_q == LenMax) begin
            ovf_d = 1'b1;
          end else begin
            len_d = len_q + 1'b1;
          end
        end
        ModeComment: begin
          if (cls == ClsNl) begin
            mode_d = ModeIdle;
          end
        end
        ModeWord: begin
          if (cls == KindVal) begin
            if (len_q == LenMax) begin
              ovf_d = 1'b1;
            end else begin
              len_d = len_q + 1'b1;
            end
          end else begin
            n         = 2'd1;
            mode_d    = ModeIdle;
            from_idle = 1'b1;
          end
        end
        ModeSlash: begin
          if (cls == ClsSl) begin
            mode_d = ModeComment;
          end else begin
            mode_d    = ModeIdle;
            from_idle = 1'b1;
          end
        end
        default: begin
          mode_d    = ModeIdle;
          from_idle = 1'b1;
        end
      endcase

      if (from_idle) begin
        if (cls == KindVal) begin
          start_d = pos_q;
          len_d   = LENGTH_BITS'(1);
          ovf_d   = 1'b0;
          mode_d  = ModeWord;
        end else if (cls == KindSq || cls == KindDq) begin
          if (n == 2'd0) begin
            tok0 = punct_tok;
          end
          n       = n + 2'd1;
          start_d = pos_q + 1'b1;
          len_d   = '0;
          ovf_d   = 1'b0;
          mode_d  = (cls == KindSq) ? ModeSq : ModeDq;
        end else if (cls == ClsSl) begin
          mode_d = ModeSlash;
        end else if (cls != ClsSkip && cls != ClsNl) begin
          if (n == 2'd0) begin
            tok0 = punct_tok;
          end
          n = n + 2'd1;
        end
      end
    end
    if (n == 2'd1) begin
      tok0.last = 1'b1;
    end
    if (n == 2'd2) begin
      tok1.last = 1'b1;
    end
  end

  assign push_o.count = fire ? n : 2'd0;
  assign push_o.tok0  = tok0;
  assign push_o.tok1  = tok1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (fire) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

### src/cct_back.sv
module cct_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cct_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cct_pkg::out_t  out_data_o
);
  import cct_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  out_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign room_o      = count_q <= CntW'(QueueDepth - 2);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = slot_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign count_d     = count_q + CntW'(push_i.count) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      slot_q[wr_ptr_q] <= push_i.tok0;
    end
    if (push_i.count == 2'd2) begin
      slot_q[wr_ptr_q + 1'b1] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.count);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue count over depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> room_o)
    else $error("push without room");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.count == 2'd0) |=> (count_q == $past(count_q) - 1'b1))
    else $error("pop did not drain queue");

endmodule

### src/char_class_tokenizer_unit.sv
// channel | direction | payload        | beat when
// in      | input     | cct_pkg::in_t  | in_valid_i && in_ready_o
// out     | output    | cct_pkg::out_t | out_valid_o && out_ready_i
//
// One beat per cycle while in_ready_o is high; classification and scan state update with it.
// Tokens pass through a four-entry queue; each token is registered there before it is output.
// Output drains a token per cycle while out_ready_i is high; two-token beats pace the input.
// in_ready_o drops only when the queue has fewer than two free entries.
// Reset clears scan mode, position, run and queue pointers; no clearing pass.
module char_class_tokenizer_unit #(
  parameter int unsigned POSITION_BITS = cct_pkg::PositionBitsDef,
  parameter int unsigned LENGTH_BITS   = cct_pkg::LengthBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cct_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cct_pkg::out_t out_data_o
);
  import cct_pkg::*;

  push_t push;
  logic  room;

  assign in_ready_o = room;

  cct_front #(
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .room_i    (room),
    .push_o    (push)
  );

  cct_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
